>>> hw/rtl/abmf_pkg.sv
// Shared types, constants and codes for the ARP IP-to-MAC binding filter.
package abmf_pkg;

   // Table geometry and field widths.
   localparam int BUCKETS      = 256;
   localparam int BUCKET_W     = $clog2(BUCKETS);
   localparam int BUCKET_LSB   = 24;
   localparam int IP_W         = 32;
   localparam int MAC_W        = 48;
   localparam int COUNT_W      = 64;
   localparam int DEFAULT_WAYS = 4;

   // Depth of the command queue and of the response queue.
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // Operation codes.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // Mode register codes.
   localparam logic [1:0] MODE_OFF         = 2'd0;
   localparam logic [1:0] MODE_LOG         = 2'd1;
   localparam logic [1:0] MODE_ENFORCE     = 2'd2;
   localparam logic [1:0] MODE_LOG_ENFORCE = 2'd3;

   // Verdict codes.
   localparam logic VERDICT_ACCEPT = 1'b0;
   localparam logic VERDICT_DROP   = 1'b1;

   // Status codes.
   localparam logic [2:0] ST_NOT_ENFORCED = 3'd0;
   localparam logic [2:0] ST_MATCH        = 3'd1;
   localparam logic [2:0] ST_IP_UNBOUND   = 3'd2;
   localparam logic [2:0] ST_MAC_MISMATCH = 3'd3;
   localparam logic [2:0] ST_UPDATED      = 3'd4;
   localparam logic [2:0] ST_INSERTED     = 3'd5;
   localparam logic [2:0] ST_BUCKET_FULL  = 3'd6;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic             op;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } req_type;

   // One response as it leaves on the result channel.
   typedef struct packed {
      logic               verdict;
      logic [2:0]         status;
      logic [COUNT_W-1:0] packets_seen;
   } rsp_type;

   // A classified request handed from the front end to the engine.
   typedef struct packed {
      req_type req;
      logic    enforce;
   } cmd_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EVAL
   } bk_state_type;

endpackage

>>> hw/rtl/abmf_front.sv
// Front end: mode register, request classification and the command queue.
module abmf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  abmf_pkg::req_type req_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data,
   input  logic              clear_busy,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output abmf_pkg::cmd_type cmd_data
);

   logic [1:0]                     mode_ff;
   abmf_pkg::cmd_type              q_ff [abmf_pkg::Q_DEPTH];
   logic [abmf_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [abmf_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [abmf_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           push_ok;
   logic                           pop_ok;
   abmf_pkg::cmd_type              cmd_new;

   // The mode register takes every write at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= abmf_pkg::MODE_OFF;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   // Classify the request: enforcement is decided by the mode at acceptance.
   always_comb begin
      cmd_new.req     = req_data;
      cmd_new.enforce = (mode_ff >= abmf_pkg::MODE_ENFORCE);
   end

   // The queue refuses requests while the table is being cleared.
   assign req_full  = clear_busy ||
                      (count_ff == abmf_pkg::QCNT_W'(abmf_pkg::Q_DEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign pop_ok    = cmd_pop && cmd_valid;
   assign cmd_data  = q_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == abmf_pkg::QPTR_W'(abmf_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == abmf_pkg::QPTR_W'(abmf_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

>>> hw/rtl/abmf_back.sv
// Engine: binding table memories, lookup and update sequencer, packet counter
// and the response queue.
module abmf_back #(
   parameter int WAYS = abmf_pkg::DEFAULT_WAYS
) (
   input  logic              clock,
   input  logic              reset,
   output logic              clear_busy,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  abmf_pkg::cmd_type cmd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output abmf_pkg::rsp_type rsp_data
);

   localparam int IPROW_W  = WAYS * abmf_pkg::IP_W;
   localparam int MACROW_W = WAYS * abmf_pkg::MAC_W;

   // Table memories, one row per bucket holding all of its ways.
   logic [WAYS-1:0]     valid_mem_ff [abmf_pkg::BUCKETS];
   logic [IPROW_W-1:0]  ip_mem_ff    [abmf_pkg::BUCKETS];
   logic [MACROW_W-1:0] mac_mem_ff   [abmf_pkg::BUCKETS];
   logic [WAYS-1:0]     valid_rd_ff;
   logic [IPROW_W-1:0]  ip_rd_ff;
   logic [MACROW_W-1:0] mac_rd_ff;

   abmf_pkg::bk_state_type             state_ff, state_in;
   logic [abmf_pkg::BUCKET_W-1:0]      clear_addr_ff, clear_addr_in;
   abmf_pkg::cmd_type                  cmd_ff;
   logic [abmf_pkg::COUNT_W-1:0]       count_ff, count_in;

   logic                               rd_en;
   logic [abmf_pkg::BUCKET_W-1:0]      rd_addr;
   logic                               valid_we;
   logic                               row_we;
   logic [abmf_pkg::BUCKET_W-1:0]      wr_addr;
   logic [WAYS-1:0]                    valid_wdata;
   logic [IPROW_W-1:0]                 ip_wdata;
   logic [MACROW_W-1:0]                mac_wdata;

   logic [WAYS-1:0]                    hit;
   logic [WAYS-1:0]                    hit_first;
   logic [WAYS-1:0]                    free;
   logic [WAYS-1:0]                    free_first;
   logic [WAYS-1:0]                    way_sel;
   logic                               any_hit;
   logic [abmf_pkg::MAC_W-1:0]         hit_mac;
   abmf_pkg::rsp_type                  rsp_new;
   logic                               rsp_push;

   // Response queue.
   abmf_pkg::rsp_type                  rq_ff [abmf_pkg::Q_DEPTH];
   logic [abmf_pkg::QPTR_W-1:0]        rq_wr_ff, rq_wr_in;
   logic [abmf_pkg::QPTR_W-1:0]        rq_rd_ff, rq_rd_in;
   logic [abmf_pkg::QCNT_W-1:0]        rq_count_ff, rq_count_in;
   logic                               rq_space;
   logic                               rq_pop_ok;

   assign rd_addr = cmd_data.req.ip[abmf_pkg::BUCKET_LSB +: abmf_pkg::BUCKET_W];

   // Memory read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         valid_rd_ff <= valid_mem_ff[rd_addr];
         ip_rd_ff    <= ip_mem_ff[rd_addr];
         mac_rd_ff   <= mac_mem_ff[rd_addr];
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem_ff[wr_addr] <= valid_wdata;
      end
      if (row_we) begin
         ip_mem_ff[wr_addr]  <= ip_wdata;
         mac_mem_ff[wr_addr] <= mac_wdata;
      end
   end

   // Per-way compare of the bucket row against the request.
   always_comb begin
      hit_mac = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = valid_rd_ff[w] &&
                  (ip_rd_ff[w*abmf_pkg::IP_W +: abmf_pkg::IP_W] == cmd_ff.req.ip);
      end
      hit_first  = hit & (~hit + 1'b1);
      any_hit    = |hit;
      free       = ~valid_rd_ff;
      free_first = free & (~free + 1'b1);
      way_sel    = any_hit ? hit_first : free_first;
      for (int w = 0; w < WAYS; w++) begin
         if (hit_first[w]) begin
            hit_mac = hit_mac | mac_rd_ff[w*abmf_pkg::MAC_W +: abmf_pkg::MAC_W];
         end
      end
   end

   // New row contents for an add: the selected way takes the binding.
   always_comb begin
      ip_wdata  = ip_rd_ff;
      mac_wdata = mac_rd_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (way_sel[w]) begin
            ip_wdata[w*abmf_pkg::IP_W +: abmf_pkg::IP_W]    = cmd_ff.req.ip;
            mac_wdata[w*abmf_pkg::MAC_W +: abmf_pkg::MAC_W] = cmd_ff.req.mac;
         end
      end
   end

   // Response for the item under evaluation.
   always_comb begin
      rsp_new.verdict      = abmf_pkg::VERDICT_ACCEPT;
      rsp_new.status       = abmf_pkg::ST_NOT_ENFORCED;
      rsp_new.packets_seen = count_ff;
      if (cmd_ff.req.op == abmf_pkg::OP_ADD) begin
         if (any_hit) begin
            rsp_new.status = abmf_pkg::ST_UPDATED;
         end else if (|free) begin
            rsp_new.status = abmf_pkg::ST_INSERTED;
         end else begin
            rsp_new.status = abmf_pkg::ST_BUCKET_FULL;
         end
      end else begin
         rsp_new.packets_seen = count_ff + 1'b1;
         if (cmd_ff.enforce) begin
            if (!any_hit) begin
               rsp_new.status  = abmf_pkg::ST_IP_UNBOUND;
               rsp_new.verdict = abmf_pkg::VERDICT_DROP;
            end else if (hit_mac == cmd_ff.req.mac) begin
               rsp_new.status = abmf_pkg::ST_MATCH;
            end else begin
               rsp_new.status  = abmf_pkg::ST_MAC_MISMATCH;
               rsp_new.verdict = abmf_pkg::VERDICT_DROP;
            end
         end
      end
   end

   // Sequencer: clearing sweep after reset, then read and evaluate each item.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      count_in      = count_ff;
      clear_busy    = 1'b0;
      cmd_pop       = 1'b0;
      rd_en         = 1'b0;
      valid_we      = 1'b0;
      row_we        = 1'b0;
      wr_addr       = cmd_ff.req.ip[abmf_pkg::BUCKET_LSB +: abmf_pkg::BUCKET_W];
      valid_wdata   = valid_rd_ff | way_sel;
      rsp_push      = 1'b0;
      case (state_ff)
         abmf_pkg::BK_CLEAR: begin
            clear_busy  = 1'b1;
            valid_we    = 1'b1;
            wr_addr     = clear_addr_ff;
            valid_wdata = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == abmf_pkg::BUCKET_W'(abmf_pkg::BUCKETS - 1)) begin
               state_in = abmf_pkg::BK_IDLE;
            end
         end
         abmf_pkg::BK_IDLE: begin
            if (cmd_valid && rq_space) begin
               cmd_pop  = 1'b1;
               rd_en    = 1'b1;
               state_in = abmf_pkg::BK_EVAL;
            end
         end
         abmf_pkg::BK_EVAL: begin
            rsp_push = 1'b1;
            count_in = rsp_new.packets_seen;
            if ((cmd_ff.req.op == abmf_pkg::OP_ADD) && (|way_sel)) begin
               valid_we = 1'b1;
               row_we   = 1'b1;
            end
            state_in = abmf_pkg::BK_IDLE;
         end
         default: begin
            state_in = abmf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= abmf_pkg::BK_CLEAR;
         clear_addr_ff <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         count_ff      <= count_in;
      end
   end

   // Latch the command as it leaves the front end's queue.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
   end

   // Response queue: a slot is reserved before an item starts.
   assign rq_space  = (rq_count_ff != abmf_pkg::QCNT_W'(abmf_pkg::Q_DEPTH));
   assign rsp_empty = (rq_count_ff == '0);
   assign rq_pop_ok = rsp_pop && !rsp_empty;
   assign rsp_data  = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in    = rq_wr_ff;
      rq_rd_in    = rq_rd_ff;
      rq_count_in = rq_count_ff;
      if (rsp_push) begin
         rq_wr_in = (rq_wr_ff == abmf_pkg::QPTR_W'(abmf_pkg::Q_DEPTH - 1)) ?
                    '0 : rq_wr_ff + 1'b1;
      end
      if (rq_pop_ok) begin
         rq_rd_in = (rq_rd_ff == abmf_pkg::QPTR_W'(abmf_pkg::Q_DEPTH - 1)) ?
                    '0 : rq_rd_ff + 1'b1;
      end
      if (rsp_push && !rq_pop_ok) begin
         rq_count_in = rq_count_ff + 1'b1;
      end else if (rq_pop_ok && !rsp_push) begin
         rq_count_in = rq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wr_ff] <= rsp_new;
      end
   end

endmodule

>>> hw/rtl/arp_ip_mac_binding_filter_unit.sv
// Top level of the ARP IP-to-MAC binding filter.
// An accepted request passes through the command queue, the engine's table read
// and its evaluate-and-write state; the response then enters the response queue.
// A new request starts after the last is done, if the response queue has room.
// Reset: synchronous; mode and the packet counter clear, then a sweep over all
// 256 buckets clears the table's valid bits while full stays high.
module arp_ip_mac_binding_filter_unit #(
   parameter int WAYS = abmf_pkg::DEFAULT_WAYS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  abmf_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output abmf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);

   logic              clear_busy;
   logic              cmd_valid;
   logic              cmd_pop;
   abmf_pkg::cmd_type cmd_data;

   // Front end: accepts and classifies requests.
   abmf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .clear_busy (clear_busy),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_data   (cmd_data)
   );

   // Engine: table lookup, update and responses.
   abmf_back #(
      .WAYS (WAYS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_data   (cmd_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
